FILE: rtl/lpht_pkg.sv
// lpht_pkg: item types, function and status codes for the linear probe hash table
// no dependencies; imported by every module of the block
package lpht_pkg;

  localparam int KEY_BITS = 16;
  localparam int VAL_BITS = 32;
  localparam int OCC_BITS = 9;

  localparam logic FN_LOOKUP = 1'b0;
  localparam logic FN_INSERT = 1'b1;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                func;
    logic [KEY_BITS-1:0] key;
    logic [VAL_BITS-1:0] value;
  } lpht_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [VAL_BITS-1:0] value_out;
    logic [OCC_BITS-1:0] occupied;
  } lpht_rsp_t;

  // classified item: request plus its home slot
  typedef struct packed {
    lpht_req_t           req;
    logic [KEY_BITS-1:0] start;
  } lpht_job_t;

endpackage

FILE: rtl/lpht_front.sv
// lpht_front: accepts items and computes the home slot key mod SLOTS
// two register stages, reciprocal multiply then multiply-subtract; uses lpht_pkg
module lpht_front #(
  parameter int SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  logic              req_valid,
  output logic              req_stall,
  input  lpht_pkg::lpht_req_t req,
  output logic              job_valid,
  input  logic              job_stall,
  output lpht_pkg::lpht_job_t job
);
  import lpht_pkg::*;

  localparam logic [63:0] RECIP_W = ((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [32:0] RECIP = RECIP_W[32:0];

  logic        s1_valid;
  lpht_req_t   s1_req;
  logic [48:0] s1_prod;
  logic        s2_valid;
  lpht_job_t   s2_job;

  logic        s1_ready;
  logic        s2_ready;
  logic [15:0] quot;
  logic [32:0] qmul;
  logic [32:0] rem;

  assign s2_ready  = !s2_valid || !job_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req_stall = !s1_ready || hold;
  assign job_valid = s2_valid;
  assign job       = s2_job;

  assign quot = s1_prod[47:32];
  assign qmul = 33'(quot) * 33'(SLOTS);
  assign rem  = 33'(s1_req.key) - qmul;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s2_ready) s2_valid <= s1_valid;
      if (s1_ready) s1_valid <= req_valid && !hold;
    end
    if (s1_ready) begin
      s1_req  <= req;
      s1_prod <= 49'(req.key) * 49'(RECIP);
    end
    if (s2_ready) begin
      s2_job.req   <= s1_req;
      s2_job.start <= rem[KEY_BITS-1:0];
    end
  end

endmodule

FILE: rtl/lpht_queue.sv
// lpht_queue: two-entry item queue between front and back
// uses lpht_pkg job type
module lpht_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpht_pkg::lpht_job_t in_job,
  output logic              out_valid,
  input  logic              out_stall,
  output lpht_pkg::lpht_job_t out_job
);
  import lpht_pkg::*;

  lpht_job_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_stall  = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_job   = entries[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) entries[wr_ptr] <= in_job;
  end

endmodule

FILE: rtl/lpht_back.sv
// lpht_back: slot store and probe sequencer, one slot read per cycle
// clears the store after reset; holds the result register; uses lpht_pkg
module lpht_back #(
  parameter int SLOTS      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              job_valid,
  output logic              job_stall,
  input  lpht_pkg::lpht_job_t job,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lpht_pkg::lpht_rsp_t rsp
);
  import lpht_pkg::*;

  localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CHECK, S_RESP} state_t;

  state_t                state;
  logic [IW-1:0]         clr;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         n;
  logic                  cur_func;
  logic [KEY_BITS-1:0]   cur_key;
  logic [VALUE_BITS-1:0] cur_val;
  logic [CW-1:0]         count;
  logic [1:0]            res_status;
  logic [VAL_BITS-1:0]   res_value;

  logic [EW-1:0]         mem [SLOTS];
  logic [EW-1:0]         rd_data;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  logic [KEY_BITS-1:0]   slot_key;
  logic [VALUE_BITS-1:0] slot_val;
  logic                  match;
  logic                  key_zero;
  logic                  empty;
  logic                  last;
  logic [IW-1:0]         idx_inc;
  logic                  take;
  logic [CW+OCC_BITS-1:0] occ_ext;

  assign slot_key  = rd_data[EW-1:VALUE_BITS];
  assign slot_val  = rd_data[VALUE_BITS-1:0];
  assign match     = (slot_key == cur_key);
  assign key_zero  = (slot_key == '0);
  assign empty     = key_zero && (slot_val == '0);
  assign last      = (n == IW'(SLOTS - 1));
  assign idx_inc   = (idx == IW'(SLOTS - 1)) ? '0 : idx + 1'b1;
  assign take      = (state == S_IDLE) && job_valid;
  assign job_stall = (state != S_IDLE);
  assign clearing  = (state == S_CLEAR);
  assign occ_ext   = (CW + OCC_BITS)'(count);

  always_comb begin
    rd_addr = idx_inc;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {cur_key, cur_val};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = job.start[IW-1:0];
      end
      S_CHECK: begin
        wr_en = (cur_func == FN_INSERT) && (match || key_zero);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_RESP) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            cur_func  <= job.req.func;
            cur_key   <= job.req.key;
            cur_val   <= VALUE_BITS'(job.req.value);
            idx       <= job.start[IW-1:0];
            n         <= '0;
            res_value <= '0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cur_func == FN_LOOKUP) begin
            if (empty) begin
              res_status <= ST_MISS;
              state      <= S_RESP;
            end else if (match) begin
              res_status <= ST_HIT;
              res_value  <= VAL_BITS'(slot_val);
              state      <= S_RESP;
            end else if (last) begin
              res_status <= ST_MISS;
              state      <= S_RESP;
            end else begin
              idx <= idx_inc;
              n   <= n + 1'b1;
            end
          end else begin
            if (match) begin
              res_status <= ST_HIT;
              state      <= S_RESP;
            end else if (key_zero) begin
              if (count < CW'(SLOTS)) count <= count + 1'b1;
              res_status <= ST_HIT;
              state      <= S_RESP;
            end else if (last) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              idx <= idx_inc;
              n   <= n + 1'b1;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.value_out <= res_value;
            rsp.occupied  <= occ_ext[OCC_BITS-1:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressing hash map with linear probing
// an item probes P slots, P from 1 to SLOTS; the back part has a single slot
// read port and takes no new item before the last is answered, but front and
// a two-entry queue keep taking items while a result waits
// reset (synchronous) starts a clearing pass over every slot; req_stall stays high
module linear_probe_hash_table #(
  parameter int SLOTS      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lpht_pkg::lpht_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lpht_pkg::lpht_rsp_t rsp
);
  import lpht_pkg::*;

  logic      clearing;
  logic      f_valid;
  logic      f_stall;
  lpht_job_t f_job;
  logic      q_valid;
  logic      q_stall;
  lpht_job_t q_job;

  lpht_front #(.SLOTS(SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (f_valid),
    .job_stall (f_stall),
    .job       (f_job)
  );

  lpht_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_job   (q_job)
  );

  lpht_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .job_valid (q_valid),
    .job_stall (q_stall),
    .job       (q_job),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    clearing |-> req_stall)
    else $error("item taken during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_HIT || rsp.status == ST_MISS || rsp.status == ST_FULL))
    else $error("bad status code");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_HIT) |-> (rsp.value_out == '0))
    else $error("value on miss or full");

endmodule
